FILE: rtl/core/spwl_pkg.sv
// Shared types and constants for the speed PI controller with low-pass filter.
// No dependencies.
package spwl_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_AW = 4;

    localparam logic [1:0] REG_SPEED_KP       = 2'd0;
    localparam logic [1:0] REG_SPEED_KI       = 2'd1;
    localparam logic [1:0] REG_INTEGRAL_LIMIT = 2'd2;
    localparam logic [1:0] REG_TILT_LIMIT     = 2'd3;

    localparam logic [14:0] INTEGRAL_LIMIT_RST = 15'd10000;
    localparam logic [14:0] TILT_LIMIT_RST     = 15'd4000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NUM,
        ST_DIV,
        ST_FILT,
        ST_INTEG,
        ST_MULP,
        ST_MULI,
        ST_ADD,
        ST_RND,
        ST_OUT
    } state_t;

endpackage

FILE: rtl/core/spwl_div5.sv
// Iterative signed divide-by-5, truncating toward zero, radix 16 (one digit per cycle).
// Depends on nothing outside this file.
module spwl_div5 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [FRAC_BITS+19:0] numer,
    output logic                      done,
    output logic signed [FRAC_BITS+17:0] quot
);

    localparam int NW     = FRAC_BITS + 20;
    localparam int FW     = FRAC_BITS + 18;
    localparam int MAGW   = NW - 1;
    localparam int DIGITS = (MAGW + 3) / 4;
    localparam int DW     = DIGITS * 4;
    localparam int CW     = $clog2(DIGITS + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic          sign_reg;
    logic [DW-1:0] mag_reg;
    logic [DW-1:0] quo_reg;
    logic [2:0]    rem_reg;

    logic [NW-1:0] mag_in;
    logic [6:0]    cur;
    logic [13:0]   recip;
    logic [3:0]    dig;
    logic [6:0]    dig5;
    logic [DW-1:0] quo_signed;

    assign mag_in = numer[NW-1] ? NW'(-numer) : NW'(numer);

    // cur < 80, so cur*205 >> 10 equals cur / 5
    assign cur   = {rem_reg, mag_reg[DW-1 -: 4]};
    assign recip = 14'(cur) * 14'd205;
    assign dig   = recip[13:10];
    assign dig5  = 7'(dig) * 7'd5;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIGITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sign_reg <= numer[NW-1];
            mag_reg  <= DW'(mag_in[MAGW-1:0]);
            quo_reg  <= '0;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[DW-5:0], 4'b0000};
            quo_reg <= {quo_reg[DW-5:0], dig};
            rem_reg <= 3'(cur - dig5);
        end
    end

    assign quo_signed = sign_reg ? DW'(-quo_reg) : quo_reg;
    assign quot       = quo_signed[FW-1:0];
    assign done       = done_reg;

endmodule

FILE: rtl/core/speed_pi_with_lowpass_core.sv
// Speed PI controller: low-pass wheel speed, clamped integral, saturated drive.
// Each accepted word passes through the states NUM, DIV (radix-16 divide-by-5 unit), FILT,
// INTEG, MULP, MULI, ADD, RND and OUT; one word in flight, next word taken the cycle
// after the result is loaded; a held result stalls output.
// Reset (aresetn low, synchronous): filter and integral state cleared, gains zero,
// integral_limit 10000, tilt_limit 4000, no result pending.
// Depends on spwl_pkg and spwl_div5.
module speed_pi_with_lowpass_core #(
    parameter int FRAC_BITS = spwl_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: left_count[15:0], right_count[31:16], target_speed[47:32], pitch[63:48]
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,
    // m_tdata: drive[15:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spwl_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    import spwl_pkg::*;

    localparam int NW  = FRAC_BITS + 20;
    localparam int FW  = FRAC_BITS + 18;
    localparam int IW  = FRAC_BITS + 16;
    localparam int IXW = FRAC_BITS + 19;
    localparam int PW  = FW + 16;
    localparam int AW  = PW + 1;
    localparam int SH  = FRAC_BITS + 8;

    localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO = -AW'(32768);
    localparam logic signed [AW-1:0] BIAS   = {{(AW-SH){1'b0}}, {SH{1'b1}}};

    state_t state_reg, state_next;

    logic signed [15:0] kp_reg;
    logic signed [15:0] ki_reg;
    logic [14:0]        ilim_reg;
    logic [14:0]        tilt_reg;

    logic signed [FW-1:0] filt_reg;
    logic signed [IW-1:0] integ_reg;
    logic signed [16:0]   sum_reg;
    logic signed [15:0]   target_reg;
    logic signed [15:0]   pitch_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] shv_reg;
    logic [15:0]          drive_reg;
    logic                 m_valid_reg;

    logic                  cfg_wr;
    logic                  div_start;
    logic                  div_done;
    logic signed [NW-1:0]  numer;
    logic signed [FW-1:0]  quot;
    logic signed [IXW-1:0] isum;
    logic signed [IXW-1:0] lim;
    logic signed [IW-1:0]  iclamp;
    logic signed [16:0]    pitch_x;
    logic signed [16:0]    tilt_x;
    logic                  tilt_over;
    logic signed [AW-1:0]  acc_b;
    logic [15:0]           drive_sat;
    logic                  out_free;
    logic signed [15:0]    mul_a;
    logic signed [FW-1:0]  mul_b;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            ilim_reg <= INTEGRAL_LIMIT_RST;
            tilt_reg <= TILT_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_SPEED_KP:       kp_reg   <= pwdata[15:0];
                REG_SPEED_KI:       ki_reg   <= pwdata[15:0];
                REG_INTEGRAL_LIMIT: ilim_reg <= pwdata[14:0];
                REG_TILT_LIMIT:     tilt_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED_KP:       prdata = 32'(kp_reg);
            REG_SPEED_KI:       prdata = 32'(ki_reg);
            REG_INTEGRAL_LIMIT: prdata = {17'd0, ilim_reg};
            REG_TILT_LIMIT:     prdata = {17'd0, tilt_reg};
            default:            prdata = '0;
        endcase
    end

    // divide unit
    assign numer     = (NW'(filt_reg) <<< 2) + (NW'(sum_reg) <<< FRAC_BITS);
    assign div_start = (state_reg == ST_NUM);

    spwl_div5 #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div5 (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .numer  (numer),
        .done   (div_done),
        .quot   (quot)
    );

    // integral update and clamp
    assign isum = IXW'(integ_reg) + IXW'(filt_reg) - (IXW'(target_reg) <<< FRAC_BITS);
    assign lim  = IXW'({1'b0, ilim_reg}) <<< FRAC_BITS;
    always_comb begin
        if (isum > lim) begin
            iclamp = IW'(lim);
        end else if (isum < -lim) begin
            iclamp = IW'(-lim);
        end else begin
            iclamp = IW'(isum);
        end
    end

    assign pitch_x   = 17'(pitch_reg);
    assign tilt_x    = $signed({2'b00, tilt_reg});
    assign tilt_over = (pitch_x > tilt_x) || (pitch_x < -tilt_x);

    // truncate toward zero, then saturate
    assign acc_b = acc_reg[AW-1] ? acc_reg + BIAS : acc_reg;
    always_comb begin
        if (shv_reg > SAT_HI) begin
            drive_sat = 16'h7fff;
        end else if (shv_reg < SAT_LO) begin
            drive_sat = 16'h8000;
        end else begin
            drive_sat = shv_reg[15:0];
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:   state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FILT;
                end
            end
            ST_FILT:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_MULP;
            ST_MULP:  state_next = ST_MULI;
            ST_MULI:  state_next = ST_ADD;
            ST_ADD:   state_next = ST_RND;
            ST_RND:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg    <= '0;
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_FILT) begin
                filt_reg <= quot;
            end
            if (state_reg == ST_INTEG) begin
                integ_reg <= iclamp;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                if (tilt_over) begin
                    integ_reg <= '0;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath, shared multiplier
    assign mul_a = (state_reg == ST_MULP) ? kp_reg : ki_reg;
    assign mul_b = (state_reg == ST_MULP) ? filt_reg : FW'(integ_reg);

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                sum_reg    <= 17'($signed(s_tdata[15:0])) + 17'($signed(s_tdata[31:16]));
                target_reg <= s_tdata[47:32];
                pitch_reg  <= s_tdata[63:48];
            end
            ST_MULP: prod_reg <= mul_a * mul_b;
            ST_MULI: begin
                acc_reg  <= AW'(prod_reg);
                prod_reg <= mul_a * mul_b;
            end
            ST_ADD:  acc_reg <= acc_reg + AW'(prod_reg);
            ST_RND:  shv_reg <= acc_b >>> SH;
            ST_OUT: begin
                if (out_free) begin
                    drive_reg <= drive_sat;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = drive_reg;

endmodule
